### src/vector_to_pan_tilt_servo_pulses_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the pan/tilt servo pulse block
// Shared clocking and reset gating for the block's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef VECTOR_TO_PAN_TILT_SERVO_PULSES_ASSERT_SVH
`define VECTOR_TO_PAN_TILT_SERVO_PULSES_ASSERT_SVH

// Property sampled on every rising clk edge, off while arst_n is low.
`define V2PT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Condition in one cycle implies a consequence in the next one.
`define V2PT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/v2pt_pkg.sv
// ----------------------------------------------------------------------------
// v2pt_pkg
// Widths, fixed-point constants, CORDIC angle table and shared types.
// ----------------------------------------------------------------------------
package v2pt_pkg;

	localparam int VECTOR_BITS  = 16;
	localparam int CORDIC_STEPS = 16;
	localparam int TAB_LEN      = 24;
	localparam int NUM_CELLS    = (CORDIC_STEPS < TAB_LEN) ? CORDIC_STEPS : TAB_LEN;
	localparam int SHW          = $clog2(TAB_LEN);
	localparam int VSHIFT       = 56 - VECTOR_BITS;
	localparam int CW           = 60;   // CORDIC x/y datapath, holds 2^55 * gain^2
	localparam int AW           = 35;   // Q30 angle, signed
	localparam int OW           = 16;   // result word

	typedef logic signed [VECTOR_BITS-1:0] vec_t;
	typedef logic [OW-1:0] word_t;

	typedef struct packed {
		logic                 valid;
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [AW-1:0] ang;
	} cordic_t;

	typedef struct packed {
		logic                 zero;
		logic signed [AW-1:0] tilt_ang;
		logic signed [AW-1:0] pan_ang;
	} scale_in_t;

	typedef struct packed {
		word_t tilt_width;
		word_t pan_width;
		word_t tilt_fraction;
		word_t pan_fraction;
		logic  planar_zero;
	} res_t;

	localparam logic signed [AW-1:0] HALF_PI_Q30 = AW'(64'd1686629713);
	localparam logic signed [AW-1:0] PI_Q30      = AW'(64'd3373259426);
	localparam logic signed [AW-1:0] TWO_PI_Q30  = AW'(64'd6746518852);
	localparam logic signed [25:0]   GAIN_Q24    = 26'sd27628053;
	localparam logic [30:0]          INV_PI_Q32  = 31'd1367130551;
	localparam logic [30:0]          TILT_PI_Q32 = 31'd956991386;
	localparam logic [34:0]          BASE_Q40    = 35'd27487790694;
	localparam logic [20:0]          TILT_SPAN_Q24 = 21'd1174405;
	localparam logic [20:0]          PAN_SPAN_Q24  = 21'd1677722;
	localparam word_t                HELD_TILT     = 16'd22938;
	localparam word_t                PERIOD_RESET  = 16'd40000;

	// floor(atan(2^-i) * 2^30)
	localparam logic [30:0] ATAN_TAB [TAB_LEN] = '{
		31'h3243F6A8, 31'h1DAC6705, 31'h0FADBAFC, 31'h07F56EA6, 31'h03FEAB76,
		31'h01FFD55B, 31'h00FFFAAA, 31'h007FFF55, 31'h003FFFEA, 31'h001FFFFD,
		31'h000FFFFF, 31'h0007FFFF, 31'h0003FFFF, 31'h0001FFFF, 31'h0000FFFF,
		31'h00007FFF, 31'h00003FFF, 31'h00001FFF, 31'h00000FFF, 31'h000007FF,
		31'h000003FF, 31'h000001FF, 31'h000000FF, 31'h0000007F
	};

	function automatic logic [30:0] atan_q30(logic [SHW-1:0] i);
		if (32'(i) < TAB_LEN) begin
			return ATAN_TAB[i];
		end
		return '0;
	endfunction

endpackage

### src/v2pt_ifs.sv
// ----------------------------------------------------------------------------
// v2pt channel interfaces
// Valid/ready channels for the vector, the period register and the results.
// ----------------------------------------------------------------------------
interface v2pt_vec_if;
	import v2pt_pkg::*;

	logic valid;
	logic ready;
	vec_t vec_x;
	vec_t vec_y;
	vec_t vec_z;

	modport source (output valid, output vec_x, output vec_y, output vec_z, input ready);
	modport sink (input valid, input vec_x, input vec_y, input vec_z, output ready);
endinterface

interface v2pt_cfg_if;
	import v2pt_pkg::*;

	logic  valid;
	logic  ready;
	word_t period_counts;

	modport source (output valid, output period_counts, input ready);
	modport sink (input valid, input period_counts, output ready);
endinterface

interface v2pt_pulse_if;
	import v2pt_pkg::*;

	logic  valid;
	logic  ready;
	word_t tilt_width;
	word_t pan_width;
	word_t tilt_fraction;
	word_t pan_fraction;
	logic  planar_zero;

	modport source (
		output valid, output tilt_width, output pan_width, output tilt_fraction,
		output pan_fraction, output planar_zero, input ready
	);
	modport sink (
		input valid, input tilt_width, input pan_width, input tilt_fraction,
		input pan_fraction, input planar_zero, output ready
	);
endinterface

### src/v2pt_cordic_cell.sv
// ----------------------------------------------------------------------------
// v2pt_cordic_cell
// One vectoring CORDIC micro-rotation, registered, handed to the next cell.
// ----------------------------------------------------------------------------
module v2pt_cordic_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [v2pt_pkg::SHW-1:0]  step,
	input  v2pt_pkg::cordic_t         d,
	output v2pt_pkg::cordic_t         q
);
	import v2pt_pkg::*;

	logic signed [CW-1:0] xs, ys, dx, dy, x_n, y_n;
	logic signed [AW-1:0] ang_i, da, ang_n;
	logic                 vld_q;
	logic signed [CW-1:0] x_q, y_q;
	logic signed [AW-1:0] ang_q;

	assign xs    = d.x;
	assign ys    = d.y;
	assign ang_i = d.ang;
	assign dx    = ys >>> step;
	assign dy    = xs >>> step;
	assign da    = AW'(atan_q30(step));

	// rotate toward y = 0
	always_comb begin
		if (ys[CW-1]) begin
			x_n   = xs - dx;
			y_n   = ys + dy;
			ang_n = ang_i - da;
		end else begin
			x_n   = xs + dx;
			y_n   = ys - dy;
			ang_n = ang_i + da;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= d.valid;
		end
	end

	always_ff @(posedge clk) begin
		x_q   <= x_n;
		y_q   <= y_n;
		ang_q <= ang_n;
	end

	assign q = '{valid: vld_q, x: x_q, y: y_q, ang: ang_q};

endmodule

### src/v2pt_scale.sv
// ----------------------------------------------------------------------------
// v2pt_scale
// Angle to Q0.16 fraction, then fraction to pulse width, six stages.
// ----------------------------------------------------------------------------
module v2pt_scale (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                go,
	input  v2pt_pkg::scale_in_t d,
	input  v2pt_pkg::word_t     held_pan,
	input  v2pt_pkg::word_t     period,
	output logic                done,
	output v2pt_pkg::res_t      res
);
	import v2pt_pkg::*;

	localparam logic [63:0] RND_Q46 = 64'd1 << 45;
	localparam logic [55:0] RND_Q40 = 56'd1 << 39;

	logic        vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic        zero_s1, zero_s2, zero_s3, zero_s4, zero_s5, zero_s6;
	logic [63:0] tprod_s1, pprod_s1;
	word_t       tfrac_s2, pfrac_s2, tfrac_s3, pfrac_s3, tfrac_s4, pfrac_s4;
	word_t       tfrac_s5, pfrac_s5, tfrac_s6, pfrac_s6;
	logic [36:0] tsp_s3, psp_s3;
	logic [37:0] tsum_s4, psum_s4;
	logic [53:0] tw_s5, pw_s5;
	word_t       twid_s6, pwid_s6;

	logic [63:0] tround, pround;
	logic [17:0] tq, pq;
	word_t       tfrac, pfrac;
	logic [55:0] twr, pwr;

	// negative -> 0, beyond two pi -> two pi
	function automatic logic [32:0] clamp_ang(logic signed [AW-1:0] a);
		if (a[AW-1]) begin
			return '0;
		end
		if (a > TWO_PI_Q30) begin
			return TWO_PI_Q30[32:0];
		end
		return a[32:0];
	endfunction

	assign tround = tprod_s1 + RND_Q46;
	assign pround = pprod_s1 + RND_Q46;
	assign tq     = tround[63:46];
	assign pq     = pround[63:46];
	assign tfrac  = zero_s1 ? HELD_TILT : ((|tq[17:16]) ? '1 : tq[15:0]);
	assign pfrac  = zero_s1 ? held_pan  : ((|pq[17:16]) ? '1 : pq[15:0]);

	// 16-bit period keeps the width at most 2^13, no saturation needed
	assign twr = {2'b00, tw_s5} + RND_Q40;
	assign pwr = {2'b00, pw_s5} + RND_Q40;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			vld_s1 <= go;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		zero_s1  <= d.zero;
		tprod_s1 <= clamp_ang(d.tilt_ang) * TILT_PI_Q32;
		pprod_s1 <= clamp_ang(d.pan_ang) * INV_PI_Q32;

		zero_s2  <= zero_s1;
		tfrac_s2 <= tfrac;
		pfrac_s2 <= pfrac;

		zero_s3  <= zero_s2;
		tfrac_s3 <= tfrac_s2;
		pfrac_s3 <= pfrac_s2;
		tsp_s3   <= tfrac_s2 * TILT_SPAN_Q24;
		psp_s3   <= pfrac_s2 * PAN_SPAN_Q24;

		zero_s4  <= zero_s3;
		tfrac_s4 <= tfrac_s3;
		pfrac_s4 <= pfrac_s3;
		tsum_s4  <= BASE_Q40 + tsp_s3;
		psum_s4  <= BASE_Q40 + psp_s3;

		zero_s5  <= zero_s4;
		tfrac_s5 <= tfrac_s4;
		pfrac_s5 <= pfrac_s4;
		tw_s5    <= period * tsum_s4;
		pw_s5    <= period * psum_s4;

		zero_s6  <= zero_s5;
		tfrac_s6 <= tfrac_s5;
		pfrac_s6 <= pfrac_s5;
		twid_s6  <= twr[55:40];
		pwid_s6  <= pwr[55:40];
	end

	assign done = vld_s6;
	assign res  = '{
		tilt_width:    twid_s6,
		pan_width:     pwid_s6,
		tilt_fraction: tfrac_s6,
		pan_fraction:  pfrac_s6,
		planar_zero:   zero_s6
	};

endmodule

### src/vector_to_pan_tilt_servo_pulses.sv
// ----------------------------------------------------------------------------
// vector_to_pan_tilt_servo_pulses
// Pointing vector to pan/tilt servo pulse widths via a row of CORDIC cells.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake      payload
//  -------  ---  -------------  ------------------------------------------------
//  vec      in   valid/ready    vec_x, vec_y, vec_z (signed VECTOR_BITS)
//  cfg      in   valid/ready    period_counts (16 b, reset 40000)
//  pulses   out  valid/ready    tilt_width, pan_width, tilt_fraction,
//                               pan_fraction, planar_zero
//
//  One request at a time. Between one accept and the next, a vector with
//  nonzero (x,y) makes two passes through the cell row (pan, then elevation)
//  and runs the six scaling stages; a vector with x = y = 0 skips the cell
//  row and runs only the scaling stages.
//  arst_n clears control, the held pan fraction and sets period to 40000.
//  A waiting result sits in the output register; the next vector is taken
//  meanwhile and only the final hand-off waits on pulses.ready.
//
module vector_to_pan_tilt_servo_pulses (
	input  logic          clk,
	input  logic          arst_n,
	v2pt_vec_if.sink      vec,
	v2pt_cfg_if.sink      cfg,
	v2pt_pulse_if.source  pulses
);
	import v2pt_pkg::*;

	// sequencer states
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_PREP  = 3'd1;  // flip / pre-rotate, launch pan pass
	localparam logic [2:0] ST_PAN   = 3'd2;  // pan pass in the cell row
	localparam logic [2:0] ST_ELEV  = 3'd3;  // elevation pass in the cell row
	localparam logic [2:0] ST_SCALE = 3'd4;  // fraction and width stages
	localparam logic [2:0] ST_DONE  = 3'd5;  // hand result to output register

	logic [2:0]           state_q;
	vec_t                 x_q, y_q, z_q;
	logic                 zero_q, flip_q;
	logic signed [CW-1:0] zk_q;
	logic signed [AW-1:0] pan_ang_q, tilt_ang_q;
	word_t                period_q, held_pan_q;
	logic                 scale_go_q;
	res_t                 res_q, out_q;
	logic                 out_valid_q;

	logic                        in_take, out_free, flip, rot;
	logic signed [VECTOR_BITS:0]   fxn, fyn;
	logic signed [VECTOR_BITS+1:0] lx, ly;
	logic signed [CW-1:0]          prep_x, prep_y, zk;
	logic signed [VECTOR_BITS+25:0] zprod;
	logic signed [AW-1:0]          elev_tilt;

	cordic_t   chain_in, chain_out;
	cordic_t   link [NUM_CELLS+1];
	scale_in_t scale_in;
	logic      scale_done;
	res_t      scale_res;

	assign in_take  = vec.valid && vec.ready;
	assign out_free = !out_valid_q || pulses.ready;

	// Flip (x,y) into the upper half plane (y <= 0 flips), then turn a
	// left-half vector by -90 degrees so the CORDIC starts with x >= 0.
	assign flip = y_q[VECTOR_BITS-1] || (y_q == '0);
	assign fxn  = flip ? -{x_q[VECTOR_BITS-1], x_q} : {x_q[VECTOR_BITS-1], x_q};
	assign fyn  = flip ? -{y_q[VECTOR_BITS-1], y_q} : {y_q[VECTOR_BITS-1], y_q};
	assign rot  = fxn[VECTOR_BITS];
	assign lx   = rot ? {fyn[VECTOR_BITS], fyn} : {fxn[VECTOR_BITS], fxn};
	assign ly   = rot ? -{fxn[VECTOR_BITS], fxn} : {fyn[VECTOR_BITS], fyn};

	// inputs move to Q(56-VECTOR_BITS) before entering the cell row
	assign prep_x = {{(CW-VECTOR_BITS-2){lx[VECTOR_BITS+1]}}, lx} << VSHIFT;
	assign prep_y = {{(CW-VECTOR_BITS-2){ly[VECTOR_BITS+1]}}, ly} << VSHIFT;

	// z carries the CORDIC gain so it matches the pan-pass magnitude
	assign zprod = z_q * GAIN_Q24;
	assign zk    = {{(CW-VECTOR_BITS-26){zprod[VECTOR_BITS+25]}}, zprod} << (VSHIFT - 24);

	// tilt is pi - elevation unless the vector was flipped
	assign elev_tilt = flip_q ? chain_out.ang : PI_Q30 - chain_out.ang;

	// cell row input: fresh vector in PREP, pan-pass magnitude with z in PAN
	always_comb begin
		chain_in.valid = ((state_q == ST_PREP) && !zero_q) ||
			((state_q == ST_PAN) && chain_out.valid);
		if (state_q == ST_PAN) begin
			chain_in.x   = chain_out.x;
			chain_in.y   = zk_q;
			chain_in.ang = '0;
		end else begin
			chain_in.x   = prep_x;
			chain_in.y   = prep_y;
			chain_in.ang = rot ? HALF_PI_Q30 : '0;
		end
	end

	// row of identical micro-rotation cells, one iteration each
	assign link[0] = chain_in;
	for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
		v2pt_cordic_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.step   (SHW'(i)),
			.d      (link[i]),
			.q      (link[i+1])
		);
	end
	assign chain_out = link[NUM_CELLS];

	assign scale_in = '{zero: zero_q, tilt_ang: tilt_ang_q, pan_ang: pan_ang_q};

	v2pt_scale u_scale (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (scale_go_q),
		.d        (scale_in),
		.held_pan (held_pan_q),
		.period   (period_q),
		.done     (scale_done),
		.res      (scale_res)
	);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			scale_go_q  <= 1'b0;
			out_valid_q <= 1'b0;
			held_pan_q  <= '0;
			period_q    <= PERIOD_RESET;
		end else begin
			scale_go_q <= 1'b0;
			if (cfg.valid && cfg.ready) begin
				period_q <= cfg.period_counts;
			end
			if (pulses.valid && pulses.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					if (zero_q) begin
						state_q    <= ST_SCALE;
						scale_go_q <= 1'b1;
					end else begin
						state_q <= ST_PAN;
					end
				end
				ST_PAN: begin
					if (chain_out.valid) begin
						state_q <= ST_ELEV;
					end
				end
				ST_ELEV: begin
					if (chain_out.valid) begin
						state_q    <= ST_SCALE;
						scale_go_q <= 1'b1;
					end
				end
				ST_SCALE: begin
					if (scale_done) begin
						state_q <= ST_DONE;
						// pan is held only across zero-planar requests
						if (!scale_res.planar_zero) begin
							held_pan_q <= scale_res.pan_fraction;
						end
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_take) begin
			x_q    <= vec.vec_x;
			y_q    <= vec.vec_y;
			z_q    <= vec.vec_z;
			zero_q <= (vec.vec_x == '0) && (vec.vec_y == '0);
		end
		if (state_q == ST_PREP) begin
			flip_q <= flip;
			zk_q   <= zk;
		end
		if ((state_q == ST_PAN) && chain_out.valid) begin
			pan_ang_q <= chain_out.ang;
		end
		if ((state_q == ST_ELEV) && chain_out.valid) begin
			tilt_ang_q <= elev_tilt;
		end
		if ((state_q == ST_SCALE) && scale_done) begin
			res_q <= scale_res;
		end
		if ((state_q == ST_DONE) && out_free) begin
			out_q <= res_q;
		end
	end

	assign vec.ready            = (state_q == ST_IDLE);
	assign cfg.ready            = 1'b1;
	assign pulses.valid         = out_valid_q;
	assign pulses.tilt_width    = out_q.tilt_width;
	assign pulses.pan_width     = out_q.pan_width;
	assign pulses.tilt_fraction = out_q.tilt_fraction;
	assign pulses.pan_fraction  = out_q.pan_fraction;
	assign pulses.planar_zero   = out_q.planar_zero;

endmodule

### src/v2pt_checker.sv
// ----------------------------------------------------------------------------
// v2pt_checker
// Port-level checks for the pan/tilt servo pulse block, bound to the top.
// ----------------------------------------------------------------------------
`include "vector_to_pan_tilt_servo_pulses_assert.svh"

module v2pt_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            in_valid,
	input logic            in_ready,
	input logic            out_valid,
	input logic            out_ready,
	input v2pt_pkg::word_t tilt_width,
	input v2pt_pkg::word_t pan_width,
	input v2pt_pkg::word_t tilt_fraction,
	input v2pt_pkg::word_t pan_fraction,
	input logic            planar_zero
);
	import v2pt_pkg::*;

	// pan fraction of the last delivered result with nonzero (x,y)
	word_t last_pan_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_pan_q <= '0;
		end else if (out_valid && out_ready && !planar_zero) begin
			last_pan_q <= pan_fraction;
		end
	end

	`V2PT_ASSERT_NEXT(a_one_request, in_valid && in_ready, !in_ready, "second request taken while busy")
	`V2PT_ASSERT(a_zero_tilt, out_valid && planar_zero |-> tilt_fraction == HELD_TILT, "zero planar tilt wrong")
	`V2PT_ASSERT(a_zero_pan, out_valid && planar_zero |-> pan_fraction == last_pan_q, "held pan not repeated")
	`V2PT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(tilt_width) && $stable(pan_width) && $stable(tilt_fraction) && $stable(pan_fraction) && $stable(planar_zero), "stalled result changed")

endmodule

bind vector_to_pan_tilt_servo_pulses v2pt_checker u_v2pt_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (vec.valid),
	.in_ready      (vec.ready),
	.out_valid     (pulses.valid),
	.out_ready     (pulses.ready),
	.tilt_width    (pulses.tilt_width),
	.pan_width     (pulses.pan_width),
	.tilt_fraction (pulses.tilt_fraction),
	.pan_fraction  (pulses.pan_fraction),
	.planar_zero   (pulses.planar_zero)
);

### tb/vector_to_pan_tilt_servo_pulses_tb.sv
// ----------------------------------------------------------------------------
// vector_to_pan_tilt_servo_pulses_tb
// Self-checking bench for the pan/tilt servo pulse block. Vectors and period
// writes are sent over valid/ready channels with random idle bursts on both
// sides. A local fixed-point CORDIC predictor computes every result, and an
// in-order scoreboard compares all five result fields.
// ----------------------------------------------------------------------------
module vector_to_pan_tilt_servo_pulses_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import v2pt_pkg::*;

	typedef longint unsigned u64_t;

	localparam int STALL_LIMIT = 2000;  // cycles with no handshake at all
	localparam int TAIL_CYCLES = 60;    // idle tail after the final drain

	// ------------------------------------------------------------------------
	// Predictor plus in-order store of expected pulse results
	// ------------------------------------------------------------------------
	class pulse_scoreboard;
		word_t period;
		word_t held_pan;
		res_t  pending_pulses[$];
		int    errors;
		int    checked;
		int    vectors;
		int    zero_vectors;

		function new();
			period   = PERIOD_RESET;
			held_pan = '0;
		endfunction

		// Vectoring CORDIC: rotates (vx,vy) onto the x axis, returns the angle.
		function longint rotate_to_axis(inout longint vx, inout longint vy);
			longint ang;
			longint dx;
			longint dy;
			ang = 0;
			for (int i = 0; i < CORDIC_STEPS && i < TAB_LEN; i++) begin
				dx = vy >>> i;
				dy = vx >>> i;
				if (vy >= 0) begin
					vx  += dx;
					vy  -= dy;
					ang += longint'(ATAN_TAB[i]);
				end else begin
					vx  -= dx;
					vy  += dy;
					ang -= longint'(ATAN_TAB[i]);
				end
			end
			return ang;
		endfunction

		// Q30 angle to Q0.16 fraction, clamped to [0, 2pi] and then to 16 bits.
		function word_t angle_to_fraction(longint ang, longint unsigned coef);
			longint          two_pi;
			longint unsigned q;
			two_pi = longint'(PI_Q30) * 2;
			if (ang < 0) ang = 0;
			if (ang > two_pi) ang = two_pi;
			q = (u64_t'(ang) * coef + (64'd1 << 45)) >> 46;
			return (q > 64'd65535) ? 16'hFFFF : q[15:0];
		endfunction

		function word_t pulse_width(word_t frac, longint unsigned span);
			longint unsigned sum;
			longint unsigned w;
			sum = u64_t'(BASE_Q40) + u64_t'(frac) * span;
			w   = (u64_t'(period) * sum + (64'd1 << 39)) >> 40;
			return (w > 64'd65535) ? 16'hFFFF : w[15:0];
		endfunction

		function res_t predict_servo_pulses(vec_t vx, vec_t vy, vec_t vz);
			res_t   r;
			longint x;
			longint y;
			longint z;
			longint fx;
			longint fy;
			longint zk;
			longint t;
			longint pan_ang;
			longint elev;
			longint tilt_ang;
			bit     flip;
			x = longint'(vx);
			y = longint'(vy);
			z = longint'(vz);
			if (x == 0 && y == 0) begin
				// no planar direction: fixed tilt, pan holds its last value
				r.tilt_fraction = HELD_TILT;
				r.pan_fraction  = held_pan;
				r.planar_zero   = 1'b1;
			end else begin
				flip    = (y <= 0);
				fx      = (flip ? -x : x) <<< VSHIFT;
				fy      = (flip ? -y : y) <<< VSHIFT;
				pan_ang = 0;
				if (fx < 0) begin
					t       = fx;
					fx      = fy;
					fy      = -t;
					pan_ang = longint'(HALF_PI_Q30);
				end
				pan_ang += rotate_to_axis(fx, fy);
				zk       = (z * longint'(GAIN_Q24)) <<< (VSHIFT - 24);
				elev     = rotate_to_axis(fx, zk);
				tilt_ang = flip ? elev : longint'(PI_Q30) - elev;
				r.tilt_fraction = angle_to_fraction(tilt_ang, TILT_PI_Q32);
				r.pan_fraction  = angle_to_fraction(pan_ang, INV_PI_Q32);
				r.planar_zero   = 1'b0;
				held_pan        = r.pan_fraction;
			end
			r.tilt_width = pulse_width(r.tilt_fraction, TILT_SPAN_Q24);
			r.pan_width  = pulse_width(r.pan_fraction, PAN_SPAN_Q24);
			return r;
		endfunction

		function void note_vector(vec_t vx, vec_t vy, vec_t vz);
			vectors++;
			if (vx == 0 && vy == 0) zero_vectors++;
			pending_pulses.push_back(predict_servo_pulses(vx, vy, vz));
		endfunction

		function void compare_field(string field, int unsigned want, int unsigned got);
			if (want != got) begin
				$error("%s: expected %0d, got %0d", field, want, got);
				errors++;
			end
		endfunction

		function void check_pulses(res_t got);
			res_t want;
			if (pending_pulses.size() == 0) begin
				$error("pulse result with no request outstanding");
				errors++;
				return;
			end
			want = pending_pulses.pop_front();
			checked++;
			compare_field("tilt_width", want.tilt_width, got.tilt_width);
			compare_field("pan_width", want.pan_width, got.pan_width);
			compare_field("tilt_fraction", want.tilt_fraction, got.tilt_fraction);
			compare_field("pan_fraction", want.pan_fraction, got.pan_fraction);
			compare_field("planar_zero", want.planar_zero, got.planar_zero);
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// Clock, reset, channels, DUT
	// ------------------------------------------------------------------------
	logic clk = 1'b0;
	logic arst_n;
	bit   idle_on = 1'b1;    // random idle bursts on both channels
	int   settings_used;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	v2pt_vec_if   vec_bus();
	v2pt_cfg_if   period_bus();
	v2pt_pulse_if pulse_bus();

	vector_to_pan_tilt_servo_pulses u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.vec    (vec_bus),
		.cfg    (period_bus),
		.pulses (pulse_bus)
	);

	pulse_scoreboard board = new();

	// ------------------------------------------------------------------------
	// Result side: ready changes on the falling edge, with random stall bursts
	// while idling is enabled; results are sampled on the rising edge.
	// ------------------------------------------------------------------------
	int stall_left;

	always @(negedge clk) begin
		if (idle_on && stall_left > 0) begin
			stall_left--;
			pulse_bus.ready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(1, 12) - 1;
			pulse_bus.ready <= 1'b0;
		end else begin
			pulse_bus.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		res_t got;
		if (arst_n && pulse_bus.valid && pulse_bus.ready) begin
			got.tilt_width    = pulse_bus.tilt_width;
			got.pan_width     = pulse_bus.pan_width;
			got.tilt_fraction = pulse_bus.tilt_fraction;
			got.pan_fraction  = pulse_bus.pan_fraction;
			got.planar_zero   = pulse_bus.planar_zero;
			board.check_pulses(got);
		end
	end

	// ------------------------------------------------------------------------
	// Watchdog: counts cycles in which no channel completes a handshake.
	// A lost result or a hung handshake ends the run here.
	// ------------------------------------------------------------------------
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (vec_bus.valid && vec_bus.ready)
					|| (period_bus.valid && period_bus.ready)
					|| (pulse_bus.valid && pulse_bus.ready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$error("no handshake for %0d cycles, %0d results outstanding",
			STALL_LIMIT, board.pending_pulses.size());
		$display("vector_to_pan_tilt_servo_pulses_tb: errors");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------------

	// One vector request. An optional idle burst comes first; the request is
	// recorded with the predictor at the edge where it is accepted.
	task automatic push_vector(input vec_t vx, input vec_t vy, input vec_t vz);
		int gap;
		gap = (idle_on && $urandom_range(0, 4) == 0) ? $urandom_range(1, 12) : 0;
		@(negedge clk);
		if (gap > 0) begin
			vec_bus.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		vec_bus.valid <= 1'b1;
		vec_bus.vec_x <= vx;
		vec_bus.vec_y <= vy;
		vec_bus.vec_z <= vz;
		do @(posedge clk); while (!vec_bus.ready);
		board.note_vector(vx, vy, vz);
	endtask

	// Stop sending and wait until every outstanding request has its result.
	task automatic drain_results();
		@(negedge clk);
		vec_bus.valid <= 1'b0;
		while (board.pending_pulses.size() > 0) @(posedge clk);
	endtask

	// Period write, only with the block idle. The new period applies to all
	// later requests.
	task automatic write_period(input word_t value);
		drain_results();
		@(negedge clk);
		period_bus.valid         <= 1'b1;
		period_bus.period_counts <= value;
		do @(posedge clk); while (!period_bus.ready);
		board.period = value;
		settings_used++;
		@(negedge clk);
		period_bus.valid <= 1'b0;
	endtask

	function automatic vec_t any_component();
		return vec_t'($urandom);
	endfunction

	function automatic vec_t edge_component();
		case ($urandom_range(0, 4))
			0:       return vec_t'(-32768);
			1:       return vec_t'(32767);
			2:       return vec_t'(-1);
			3:       return vec_t'(1);
			default: return vec_t'(0);
		endcase
	endfunction

	// Random vector mix: mostly full range, with enough x=y=0, on-axis,
	// tiny and extreme vectors to hit the flip, rotate and clamp paths.
	task automatic push_random_vector();
		int   pick;
		vec_t vx;
		vec_t vy;
		vec_t vz;
		pick = $urandom_range(0, 99);
		vx   = any_component();
		vy   = any_component();
		vz   = any_component();
		if (pick < 8) begin
			vx = '0;
			vy = '0;
		end else if (pick < 20) begin
			if ($urandom_range(0, 1)) vx = '0;
			else vy = '0;
		end else if (pick < 35) begin
			vx = vec_t'($urandom_range(0, 16) - 8);
			vy = vec_t'($urandom_range(0, 16) - 8);
			if ($urandom_range(0, 1)) vz = vec_t'($urandom_range(0, 16) - 8);
		end else if (pick < 45) begin
			vx = edge_component();
			vy = edge_component();
			vz = edge_component();
		end
		push_vector(vx, vy, vz);
	endtask

	task automatic run_random_phase(input int count);
		for (int n = 0; n < count; n++) begin
			// occasionally let the pipeline run completely dry
			if (idle_on && (n == count / 2 || $urandom_range(0, 79) == 0)) drain_results();
			push_random_vector();
		end
	endtask

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		arst_n                   = 1'b0;
		vec_bus.valid            = 1'b0;
		vec_bus.vec_x            = '0;
		vec_bus.vec_y            = '0;
		vec_bus.vec_z            = '0;
		period_bus.valid         = 1'b0;
		period_bus.period_counts = '0;
		pulse_bus.ready          = 1'b0;
		stall_left               = 0;
		settings_used            = 1;    // reset period counts as one setting

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed requests at the reset period.
		push_vector(16'sd0, 16'sd0, 16'sd0);            // x=y=0, held pan still 0
		push_vector(16'sd1000, 16'sd0, 16'sd0);         // y=0 flips, x<0 after flip
		push_vector(-16'sd1000, 16'sd0, 16'sd0);        // angle may end just below 0
		push_vector(16'sd0, 16'sd0, 16'sd32767);        // x=y=0 holds a pan near 0
		push_vector(16'sd0, 16'sd1000, 16'sd0);
		push_vector(16'sd0, -16'sd1000, 16'sd0);
		push_vector(16'sd32767, 16'sd32767, 16'sd32767);
		push_vector(-16'sd32768, -16'sd32768, -16'sd32768);
		push_vector(-16'sd32768, 16'sd32767, -16'sd32768);
		push_vector(16'sd1, 16'sd1, -16'sd32768);       // tilt past pi/0.7 saturates
		push_vector(16'sd0, 16'sd1, -16'sd32768);
		push_vector(-16'sd32768, 16'sd1, 16'sd0);       // pan just short of pi
		push_vector(16'sd5, -16'sd5, -16'sd20000);      // flipped, negative tilt angle
		push_vector(16'sd0, 16'sd0, -16'sd32768);
		push_vector(16'sd1, 16'sd0, 16'sd0);
		push_vector(-16'sd1, -16'sd1, -16'sd1);
		push_vector(16'sd1, 16'sd1, 16'sd1);
		push_vector(16'sd32767, -16'sd32768, 16'sd32767);
		push_vector(16'sd0, 16'sd32767, 16'sd32767);
		push_vector(16'sd32767, 16'sd0, -16'sd32768);
		push_vector(16'sd0, -16'sd32768, 16'sd32767);
		push_vector(-16'sd12345, 16'sd23456, 16'sd0);

		// Random phases, each behind a period write at an idle block.
		write_period(16'hFFFF);
		run_random_phase(150);
		write_period(16'd0);        // zero period gives zero widths
		run_random_phase(50);
		write_period(16'd1);
		run_random_phase(60);
		write_period(word_t'($urandom_range(2, 65534)));
		run_random_phase(170);
		write_period(16'd12345);
		run_random_phase(150);

		// Last part: back to the reset period, both sides at full rate.
		write_period(PERIOD_RESET);
		idle_on = 1'b0;
		run_random_phase(150);

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d vector requests (%0d with x=y=0) over %0d period settings",
			board.vectors, board.zero_vectors, settings_used);
		$display("checked %0d pulse results, %0d field mismatches",
			board.checked, board.errors);
		if (board.errors == 0) begin
			$display("vector_to_pan_tilt_servo_pulses_tb: clean");
		end else begin
			$display("vector_to_pan_tilt_servo_pulses_tb: errors");
		end
		$finish;
	end

endmodule
